/* hw/rtl/vndt_pkg.sv */
// shared types and constants for the value numbering table
package vndt_pkg;
    localparam int unsigned TableSlots  = 256;
    localparam int unsigned ValueIdBits = 16;
    localparam logic [63:0] HashMult    = 64'h3141592653589793;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture request, clear hash state
        logic mix_step;    // one hash mix step
        logic set_home;    // take home slot from hash
        logic rd;          // issue slot read at probe index
        logic advance;     // move probe index
        logic ins;         // write key at probe index
        logic clr_start;   // start invalidation sweep
        logic clr_step;    // invalidate one slot
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mix_last;
        logic slot_valid;
        logic key_match;
        logic wrapped;
        logic at_limit;
        logic clr_last;
    } t_status;
endpackage

/* hw/rtl/vndt_if.sv */
// valid/ready channel carrying one payload
interface vndt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/vndt_datapath.sv */
// hash unit, slot memories and probe index
module vndt_datapath #(
    parameter int unsigned TABLE_SLOTS   = vndt_pkg::TableSlots,
    parameter int unsigned VALUE_ID_BITS = vndt_pkg::ValueIdBits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vndt_pkg::t_cmd    i_cmd,
    output vndt_pkg::t_status o_status,
    input  logic [19:0]       i_rest,
    input  logic [63:0]       i_imm,
    input  logic [15:0]       i_first,
    input  logic [15:0]       i_second,
    input  logic [15:0]       i_label,
    input  logic [15:0]       i_own,
    output logic [15:0]       o_value
);
    import vndt_pkg::*;
    localparam int unsigned IdxW  = $clog2(TABLE_SLOTS);
    localparam int unsigned CntW  = IdxW + 1;
    localparam int unsigned Limit = (3 * TABLE_SLOTS) / 4;
    localparam int unsigned IdW   = VALUE_ID_BITS < 16 ? VALUE_ID_BITS : 16;
    localparam int unsigned KeyW  = 20 + 64 + 16 + 16 + 16;

    // registered key
    logic [KeyW-1:0] r_key;
    logic [15:0]     r_own;
    logic [15:0]     w_first, w_second, w_own;
    always_comb begin
        w_first  = '0; w_second = '0; w_own = '0;
        w_first[IdW-1:0]  = i_first[IdW-1:0];
        w_second[IdW-1:0] = i_second[IdW-1:0];
        w_own[IdW-1:0]    = i_own[IdW-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= {i_rest, (i_rest[18] ? i_imm : 64'd0), w_first, w_second,
                      (i_rest[19] ? i_label : 16'd0)};
            r_own <= w_own;
        end
    end

    // hash: four words, each mixed in turn with one 32x32 multiplier
    // low 64 bits of x*m = xl*ml + ((xl*mh + xh*ml) << 32)
    logic [63:0] r_h, r_p;
    logic [3:0]  r_step;
    logic [63:0] w_word, w_x, w_prod;
    logic [31:0] w_ma, w_mb;
    always_comb begin
        case (r_step[3:2])
            2'd0:    w_word = {44'd0, r_key[KeyW-1 -: 20]};
            2'd1:    w_word = r_key[111:48];
            2'd2:    w_word = {16'd0, r_key[31:16], 16'd0, r_key[47:32]};
            default: w_word = {48'd0, r_key[15:0]};
        endcase
    end
    assign w_x    = r_h ^ w_word;
    assign w_ma   = (r_step[1:0] == 2'd2) ? w_x[63:32] : w_x[31:0];
    assign w_mb   = (r_step[1:0] == 2'd1) ? HashMult[63:32] : HashMult[31:0];
    assign w_prod = w_ma * w_mb;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h <= '0; r_step <= '0;
        end else if (i_cmd.mix_step) begin
            case (r_step[1:0])
                2'd0:    r_p <= w_prod;
                2'd1,
                2'd2:    r_p <= r_p + {w_prod[31:0], 32'd0};
                default: r_h <= r_p ^ (r_p >> 29);
            endcase
            r_step <= r_step + 4'd1;
        end
    end
    assign o_status.mix_last = (r_step == 4'd15);

    // probe index and sweep
    logic [IdxW-1:0] r_idx;
    logic [CntW-1:0] r_cnt, r_used;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd.clr_start) r_used <= '0;
            else if (i_cmd.ins) r_used <= r_used + CntW'(1);
        end
        if (i_cmd.set_home) begin
            r_idx <= r_h[32 +: IdxW];
            r_cnt <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IdxW'(1);
            r_cnt <= r_cnt + CntW'(1);
        end else if (i_cmd.clr_start) begin
            r_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_idx <= r_idx + IdxW'(1);
        end
    end
    assign o_status.wrapped  = (r_cnt == CntW'(TABLE_SLOTS));
    assign o_status.at_limit = (r_used >= CntW'(Limit));
    assign o_status.clr_last = (r_idx == {IdxW{1'b1}});

    // valid bits
    logic [TABLE_SLOTS-1:0] r_valid;
    logic                   r_vq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clr_step) begin
            r_valid[r_idx] <= 1'b0;
        end else if (i_cmd.ins) begin
            r_valid[r_idx] <= 1'b1;
        end
        if (i_cmd.rd) r_vq <= r_valid[r_idx];
    end

    // slot memories
    logic [KeyW-1:0] m_key [TABLE_SLOTS];
    logic [15:0]     m_val [TABLE_SLOTS];
    logic [KeyW-1:0] r_kq;
    logic [15:0]     r_valq;
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            m_key[r_idx] <= r_key;
            m_val[r_idx] <= r_own;
        end
        if (i_cmd.rd) begin
            r_kq   <= m_key[r_idx];
            r_valq <= m_val[r_idx];
        end
    end
    assign o_status.slot_valid = r_vq;
    assign o_status.key_match  = (r_kq == r_key);
    assign o_value = r_valq;
endmodule

/* hw/rtl/vndt_ctrl.sv */
// sequencer for hashing, probing, insert and clear
module vndt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_hit,
    output logic              o_full,
    output logic              o_take_value,
    output vndt_pkg::t_cmd    o_cmd,
    input  vndt_pkg::t_status i_status
);
    import vndt_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_READ = 3'd2,
                           S_CHECK = 3'd3, S_CLEAR = 3'd4, S_DONE = 3'd5,
                           S_HOME = 3'd6;
    logic [2:0] r_state, n_state;
    logic       r_ov, n_ov, r_hit, n_hit, r_full, n_full, n_take;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_full  = r_full;
    assign o_take_value = n_take;

    // next state and commands
    always_comb begin
        n_state = r_state; n_ov = r_ov && !i_ready; n_hit = r_hit; n_full = r_full;
        n_take = 1'b0;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    if (i_command) begin
                        n_state = S_HASH;
                    end else begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_HASH: begin
                o_cmd.mix_step = 1'b1;
                if (i_status.mix_last) n_state = S_HOME;
            end
            S_HOME: begin
                o_cmd.set_home = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_status.wrapped) begin
                    n_hit = 1'b0; n_full = 1'b1; n_take = 1'b1; n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.slot_valid) begin
                    n_hit = 1'b0; n_take = 1'b1;
                    n_full = i_status.at_limit;
                    o_cmd.ins = !i_status.at_limit;
                    n_state = S_DONE;
                end else if (i_status.key_match) begin
                    n_hit = 1'b1; n_full = 1'b0; n_take = 1'b1; n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_hit = 1'b0; n_full = 1'b0; n_take = 1'b1; n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ov <= n_ov;
        end
        r_hit <= n_hit; r_full <= n_full;
    end
endmodule

/* hw/rtl/value_numbering_dedup_table_top.sv */
// value numbering table: lookup-or-insert with linear probing
// sequence: load, hash (one 32x32 product per cycle), home, then a read and a check
// per probed slot, and a done state to finish
// requests: one at a time; probes bound by the single read port of the slot
// memory
// clear sweeps all slots, one per cycle
// reset: synchronous active low, all slots invalid, count zero
module value_numbering_dedup_table_top #(
    parameter int unsigned TABLE_SLOTS   = vndt_pkg::TableSlots,
    parameter int unsigned VALUE_ID_BITS = vndt_pkg::ValueIdBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vndt_if.sink   i_req,
    vndt_if.source o_rsp
);
    import vndt_pkg::*;
    t_cmd    w_cmd;
    t_status w_st;
    logic    w_hit, w_full, w_take;
    logic [15:0] w_val, r_val;

    vndt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .i_command(i_req.data.command), .o_ready(i_req.ready),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready),
        .o_hit(w_hit), .o_full(w_full), .o_take_value(w_take),
        .o_cmd(w_cmd), .i_status(w_st)
    );

    vndt_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .VALUE_ID_BITS(VALUE_ID_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_st),
        .i_rest({i_req.data.uses_label, i_req.data.uses_immediate, i_req.data.narrow_mode,
                 i_req.data.access_size, i_req.data.sign_extend, i_req.data.op_type}),
        .i_imm(i_req.data.immediate), .i_first(i_req.data.first_operand),
        .i_second(i_req.data.second_operand), .i_label(i_req.data.label_id),
        .i_own(i_req.data.own_value), .o_value(w_val)
    );

    // latch returned value on completion, masked by hit at the output
    always_ff @(posedge i_clk) begin
        if (w_take) r_val <= w_val;
    end

    assign o_rsp.data.hit           = w_hit;
    assign o_rsp.data.matched_value = w_hit ? r_val : 16'd0;
    assign o_rsp.data.table_full    = w_full;
endmodule
